>>> rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Types, constants and round functions shared by the block cipher pipeline.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int HALF_ROUNDS = 16;
    localparam int NUM_KEYS = 8;
    localparam int NUM_ROWS = 8;
    localparam int ROUND_W = 5;
    localparam int ADDR_W = 6;
    localparam int ROT = 11;

    localparam logic [1:0] MODE_ENC32 = 2'd0;
    localparam logic [1:0] MODE_DEC32 = 2'd1;
    localparam logic [1:0] MODE_ENC16 = 2'd2;
    localparam logic [1:0] MODE_DEC16 = 2'd3;

    typedef logic [NUM_ROWS-1:0][63:0] t_sbox;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [31:0]                n1;
        logic [31:0]                n2;
        logic [NUM_KEYS-1:0][31:0]  keys;
    } t_item;

    function automatic logic [2:0] key_sel(input logic [1:0] mode,
                                           input logic [ROUND_W-1:0] round);
        logic [2:0] fwd;
        logic [2:0] rev;
        logic [2:0] sel;
        fwd = round[2:0];
        rev = ~round[2:0];
        case (mode)
            MODE_ENC32: sel = (round < ROUND_W'(24)) ? fwd : rev;
            MODE_DEC32: sel = (round < ROUND_W'(8)) ? fwd : rev;
            MODE_ENC16: sel = fwd;
            default:    sel = rev;
        endcase
        return sel;
    endfunction

    function automatic logic [31:0] round_f(input logic [31:0] x, input t_sbox rows);
        logic [31:0] s;
        logic [3:0]  v;
        s = '0;
        for (int p = 0; p < NUM_ROWS; p++) begin
            v = x[4*p +: 4];
            s[4*p +: 4] = rows[p][4*v +: 4];
        end
        return {s[31-ROT:0], s[31:32-ROT]};
    endfunction

endpackage

>>> rtl/gbc_cfg.sv
// ----------------------------------------------------------------------------
// gbc_cfg
// Register file for the eight substitution rows, written and read over apb.
// ----------------------------------------------------------------------------
module gbc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output gbc_pkg::t_sbox              o_sbox
);

    gbc_pkg::t_sbox r_sbox;
    logic [2:0]     w_idx;

    assign w_idx  = paddr[gbc_pkg::ADDR_W-1:3];
    assign prdata = r_sbox[w_idx];
    assign o_sbox = r_sbox;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbox <= '0;
        end else if (psel && penable && pwrite) begin
            r_sbox[w_idx] <= pwdata;
        end
    end

endmodule

>>> rtl/gbc_round.sv
// ----------------------------------------------------------------------------
// gbc_round
// One registered round stage: key add, substitution, rotate and xor; inactive stages pass the item unchanged.
// ----------------------------------------------------------------------------
module gbc_round (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [gbc_pkg::ROUND_W-1:0]   i_round,
    input  gbc_pkg::t_sbox                i_sbox,
    input  logic                          i_valid,
    input  gbc_pkg::t_item                i_item,
    output logic                          o_valid,
    output gbc_pkg::t_item                o_item
);

    logic               w_active;
    logic [2:0]         w_ksel;
    logic [31:0]        w_src;
    logic [31:0]        w_f;
    gbc_pkg::t_item     n_item;
    gbc_pkg::t_item     r_item;
    logic               r_valid;

    always_comb begin
        w_active = (i_item.mode == gbc_pkg::MODE_ENC32) ||
                   (i_item.mode == gbc_pkg::MODE_DEC32) ||
                   (i_round < gbc_pkg::ROUND_W'(gbc_pkg::HALF_ROUNDS));
        w_ksel = gbc_pkg::key_sel(i_item.mode, i_round);
        w_src  = i_round[0] ? i_item.n2 : i_item.n1;
        w_f    = gbc_pkg::round_f(w_src + i_item.keys[w_ksel], i_sbox);
        n_item = i_item;
        if (w_active) begin
            if (i_round[0]) begin
                n_item.n1 = i_item.n1 ^ w_f;
            end else begin
                n_item.n2 = i_item.n2 ^ w_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/gost_block_cipher.sv
// ----------------------------------------------------------------------------
// gost_block_cipher
// Fully unrolled 64-bit block cipher, one round per pipeline stage.
// start reaches o_valid through 32 registered round stages and one output stage
// throughput: one word per cycle in every mode; busy is always low
// 16-round modes pass unchanged through the last 16 stages
// synchronous active-low reset clears the stage valids and substitution rows
// results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module gost_block_cipher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_mode,
    input  logic [63:0]                 i_block,
    input  logic [31:0]                 i_key_word_0,
    input  logic [31:0]                 i_key_word_1,
    input  logic [31:0]                 i_key_word_2,
    input  logic [31:0]                 i_key_word_3,
    input  logic [31:0]                 i_key_word_4,
    input  logic [31:0]                 i_key_word_5,
    input  logic [31:0]                 i_key_word_6,
    input  logic [31:0]                 i_key_word_7,
    output logic                        o_valid,
    output logic [63:0]                 o_result_block,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    gbc_pkg::t_sbox w_sbox;
    logic           w_valid [0:gbc_pkg::NUM_ROUNDS];
    gbc_pkg::t_item w_item  [0:gbc_pkg::NUM_ROUNDS];
    gbc_pkg::t_item w_last;
    logic           r_out_valid;
    logic [63:0]    r_out_block;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    gbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_sbox  (w_sbox)
    );

    assign w_valid[0]      = start;
    assign w_item[0].mode  = i_mode;
    assign w_item[0].n1    = i_block[31:0];
    assign w_item[0].n2    = i_block[63:32];
    assign w_item[0].keys  = {i_key_word_7, i_key_word_6, i_key_word_5, i_key_word_4,
                              i_key_word_3, i_key_word_2, i_key_word_1, i_key_word_0};

    for (genvar g = 0; g < gbc_pkg::NUM_ROUNDS; g++) begin : g_round
        gbc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (gbc_pkg::ROUND_W'(g)),
            .i_sbox  (w_sbox),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    assign w_last = w_item[gbc_pkg::NUM_ROUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_valid[gbc_pkg::NUM_ROUNDS];
        end
    end

    // 16-round encrypt keeps n1 in the low half
    always_ff @(posedge i_clk) begin
        if (w_last.mode == gbc_pkg::MODE_ENC16) begin
            r_out_block <= {w_last.n2, w_last.n1};
        end else begin
            r_out_block <= {w_last.n1, w_last.n2};
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_block = r_out_block;

endmodule

>>> rtl/gbc_checker.sv
// ----------------------------------------------------------------------------
// gbc_checker
// Port-level checks on the block cipher, bound to the top level.
// ----------------------------------------------------------------------------
module gbc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        o_valid,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    input  logic [63:0]                 prdata,
    input  logic                        pready
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##33 o_valid)
        else $error("word lost in pipeline");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 33))
        else $error("result without a word");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(psel && penable && pwrite && pready) && $past(i_rst_n) && psel && !pwrite
         && paddr[gbc_pkg::ADDR_W-1:3] == $past(paddr[gbc_pkg::ADDR_W-1:3]))
        |-> prdata == $past(pwdata))
        else $error("register readback mismatch");

endmodule

bind gost_block_cipher gbc_checker u_gbc_checker (.*);
